/* src/fpa_pkg.sv */
package fpa_pkg;

  // Default geometry: Q24.8 in a 32-bit word.
  localparam int FPA_WORD_BITS = 32;
  localparam int FPA_FRAC_BITS = 8;

  // Command field.
  localparam int CMD_BITS = 4;
  typedef logic [CMD_BITS-1:0] cmd_t;

  localparam cmd_t CMD_ADD      = 4'd0;
  localparam cmd_t CMD_SUB      = 4'd1;
  localparam cmd_t CMD_MUL      = 4'd2;
  localparam cmd_t CMD_DIV      = 4'd3;
  localparam cmd_t CMD_MIN      = 4'd4;
  localparam cmd_t CMD_MAX      = 4'd5;
  localparam cmd_t CMD_INC      = 4'd6;
  localparam cmd_t CMD_DEC      = 4'd7;
  localparam cmd_t CMD_TO_INT   = 4'd8;
  localparam cmd_t CMD_FROM_INT = 4'd9;

endpackage

/* src/fixed_point_q24_8_alu.sv */
// Signed fixed-point ALU (WORD_BITS wide, FRAC_BITS fraction bits, Q24.8 by
// default) that takes one transaction per clock and returns one result per
// transaction in order. Every command runs through the same pipeline of
// WORD_BITS + FRAC_BITS + 2 register stages: an
// input stage, one restoring-division stage per quotient bit of the
// (WORD_BITS + FRAC_BITS)-bit scaled dividend, and an output stage. The
// multiplier sits in the first division stage and its sign fix-up and scaling
// in the output stage. The divider length sets the latency; throughput is one
// transaction per cycle. A stall on the result side holds the whole pipeline,
// and the input stall follows it in the same cycle. Division by zero returns
// zero with divide_by_zero set; min and max return operand_b on a tie, and
// unused command codes return zero with valid compare flags.
module fixed_point_q24_8_alu
  import fpa_pkg::*;
#(
  parameter int WORD_BITS = FPA_WORD_BITS,
  parameter int FRAC_BITS = FPA_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel
  input  logic                        valid,
  output logic                        stall,
  input  logic [CMD_BITS-1:0]         command,
  input  logic signed [WORD_BITS-1:0] operand_a,
  input  logic signed [WORD_BITS-1:0] operand_b,
  // Result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [WORD_BITS-1:0] result,
  output logic                        a_less,
  output logic                        a_equal,
  output logic                        a_greater,
  output logic                        divide_by_zero
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int N = WORD_BITS + FRAC_BITS;  // quotient bits = divider stages

  typedef struct packed {
    logic         is_mul;
    logic         is_div;
    logic         dz;
    logic         neg;
    logic         lt;
    logic         eq;
    logic         gt;
    logic [W-1:0] simple;
    logic [W-1:0] mb;
    logic [W-1:0] rem;
    logic [N-1:0] qd;
    logic [2*W-1:0] prod;
  } stage_t;

  stage_t       stg [0:N];
  logic [N:0]   vld;
  logic         en;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en    = !result_valid || !result_stall;
  assign stall = !en;

  // Input decode: compare flags, magnitudes and the results of all simple commands.
  stage_t       stg0_next;
  logic         lt_in;
  logic         gt_in;
  logic [W-1:0] ma_in;
  logic [W-1:0] mb_in;
  logic [W-1:0] ti_in;

  always_comb begin
    lt_in = operand_a < operand_b;
    gt_in = operand_a > operand_b;
    ma_in = operand_a[W-1] ? W'(-operand_a) : operand_a;
    mb_in = operand_b[W-1] ? W'(-operand_b) : operand_b;
    ti_in = {{F{1'b0}}, ma_in[W-1:F]};

    stg0_next.is_mul = (command == CMD_MUL);
    stg0_next.is_div = (command == CMD_DIV);
    stg0_next.dz     = (command == CMD_DIV) && (operand_b == '0);
    stg0_next.neg    = operand_a[W-1] ^ operand_b[W-1];
    stg0_next.lt     = lt_in;
    stg0_next.eq     = (operand_a == operand_b);
    stg0_next.gt     = gt_in;
    stg0_next.mb     = mb_in;
    stg0_next.rem    = '0;
    stg0_next.qd     = {ma_in, {F{1'b0}}};
    stg0_next.prod   = '0;

    unique case (command)
      CMD_ADD:      stg0_next.simple = operand_a + operand_b;
      CMD_SUB:      stg0_next.simple = operand_a - operand_b;
      CMD_MIN:      stg0_next.simple = lt_in ? operand_a : operand_b;
      CMD_MAX:      stg0_next.simple = gt_in ? operand_a : operand_b;
      CMD_INC:      stg0_next.simple = operand_a + W'(1);
      CMD_DEC:      stg0_next.simple = operand_a - W'(1);
      CMD_TO_INT:   stg0_next.simple = operand_a[W-1] ? W'(-ti_in) : ti_in;
      CMD_FROM_INT: stg0_next.simple = {operand_a[W-F-1:0], {F{1'b0}}};
      default:      stg0_next.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= stg0_next;
    end
  end

  // Valid bits travel alongside the stage payloads.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-1:0], valid};
    end
  end

  // One restoring-division step per stage; the first stage also multiplies.
  // The qd register shifts dividend bits out at the top and quotient bits in
  // at the bottom, so it holds the full quotient after the last stage.
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0]   trial;
    logic         ge;
    logic [W:0]   diff;
    stage_t       nxt;

    always_comb begin
      trial = {stg[k-1].rem, stg[k-1].qd[N-1]};
      ge    = trial >= {1'b0, stg[k-1].mb};
      diff  = trial - {1'b0, stg[k-1].mb};
      nxt     = stg[k-1];
      nxt.rem = ge ? diff[W-1:0] : trial[W-1:0];
      nxt.qd  = {stg[k-1].qd[N-2:0], ge};
      if (k == 1) begin
        nxt.prod = {{W{1'b0}}, stg[0].qd[N-1 -: W]} * {{W{1'b0}}, stg[0].mb};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt;
      end
    end
  end

  // Output stage: sign fix-up of quotient and product, then result select.
  logic [2*W-1:0] sprod;
  logic [W-1:0]   quot;
  logic [W-1:0]   res_next;

  always_comb begin
    sprod = stg[N].neg ? (2*W)'(-stg[N].prod) : stg[N].prod;
    quot  = stg[N].neg ? W'(-stg[N].qd[W-1:0]) : stg[N].qd[W-1:0];
    priority if (stg[N].is_div) begin
      res_next = stg[N].dz ? '0 : quot;
    end else if (stg[N].is_mul) begin
      res_next = sprod[W+F-1:F];
    end else begin
      res_next = stg[N].simple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result         <= res_next;
      a_less         <= stg[N].lt;
      a_equal        <= stg[N].eq;
      a_greater      <= stg[N].gt;
      divide_by_zero <= stg[N].dz;
    end
  end

  // Checks on the pipeline's own logic.
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags are not exactly one of less, equal, greater");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && divide_by_zero |-> result == '0)
    else $error("divide by zero did not return zero");

  a_hold_stalls_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> stall)
    else $error("input taken while the result register is held");

  a_dz_not_less_equal: assert property (@(posedge clk) disable iff (rst)
    result_valid && divide_by_zero |-> !a_equal || !a_less)
    else $error("inconsistent flags on a divide by zero result");

endmodule

/* tb/fixed_point_q24_8_alu_tb.sv */
module fixed_point_q24_8_alu_tb;
  import fpa_pkg::*;

  localparam int W = FPA_WORD_BITS;
  localparam int FRAC = FPA_FRAC_BITS;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 100;

  // Command codes the block does not define; they must return zero.
  localparam cmd_t CMD_UNUSED_LO = 4'd10;
  localparam cmd_t CMD_UNUSED_HI = 4'd15;

  typedef logic signed [W-1:0] word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // One expected result transaction.
  typedef struct packed {
    word_t value;
    logic  lt;
    logic  eq;
    logic  gt;
    logic  dz;
  } alu_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  cmd_t        command = CMD_ADD;
  word_t       operand_a = '0;
  word_t       operand_b = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  word_t       result;
  logic        a_less;
  logic        a_equal;
  logic        a_greater;
  logic        divide_by_zero;

  alu_out_t    predicted_results[$];
  int          mismatches = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  int          hold_cycles = 0;

  fixed_point_q24_8_alu uut (
    .clk           (clk),
    .rst           (rst),
    .valid         (valid),
    .stall         (stall),
    .command       (command),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .a_less        (a_less),
    .a_equal       (a_equal),
    .a_greater     (a_greater),
    .divide_by_zero(divide_by_zero)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Computes the result transaction that one command and operand pair produces.
  function automatic alu_out_t predict_alu_result(cmd_t cmd_v, word_t a_v, word_t b_v);
    alu_out_t o;
    longint a64;
    longint b64;
    longint mag_a;
    longint mag_b;
    longint wide;
    a64 = a_v;
    b64 = b_v;
    mag_a = (a64 < 0) ? -a64 : a64;
    mag_b = (b64 < 0) ? -b64 : b64;
    o.lt = a_v < b_v;
    o.eq = a_v == b_v;
    o.gt = a_v > b_v;
    o.dz = 1'b0;
    o.value = '0;
    case (cmd_v)
      CMD_ADD: o.value = a_v + b_v;
      CMD_SUB: o.value = a_v - b_v;
      CMD_MUL: begin
        // The full 64-bit product is scaled back down, rounding toward minus infinity.
        wide = a64 * b64;
        o.value = word_t'(wide >>> FRAC);
      end
      CMD_DIV: begin
        if (b_v == '0) begin
          o.dz = 1'b1;
        end else begin
          // Magnitudes divide with truncation; the sign is applied afterwards.
          wide = (mag_a << FRAC) / mag_b;
          if ((a64 < 0) != (b64 < 0)) wide = -wide;
          o.value = word_t'(wide);
        end
      end
      CMD_MIN: o.value = (a_v < b_v) ? a_v : b_v;
      CMD_MAX: o.value = (a_v > b_v) ? a_v : b_v;
      CMD_INC: o.value = a_v + word_t'(1);
      CMD_DEC: o.value = a_v - word_t'(1);
      CMD_TO_INT: begin
        wide = mag_a >> FRAC;
        if (a64 < 0) wide = -wide;
        o.value = word_t'(wide);
      end
      CMD_FROM_INT: o.value = a_v <<< FRAC;
      default: o.value = '0;
    endcase
    return o;
  endfunction

  // Draws an operand from a mix of full-range, small, integral and edge values.
  function automatic word_t pick_operand();
    case ($urandom_range(0, 7))
      0, 1, 2: return word_t'($urandom);
      3: return word_t'(int'($urandom_range(0, 4095)) - 2048);
      4: return word_t'((int'($urandom_range(0, 1023)) - 512) * (1 << FRAC));
      5: begin
        case ($urandom_range(0, 4))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return word_t'(0);
          3: return word_t'(-1);
          default: return word_t'(1);
        endcase
      end
      6: begin
        if ($urandom_range(0, 1) == 0) return WORD_MAX - word_t'($urandom_range(0, 255));
        return WORD_MIN + word_t'($urandom_range(0, 255));
      end
      default: return word_t'($urandom) >>> $urandom_range(0, W - 1);
    endcase
  endfunction

  // Offers one transaction and waits until the block accepts it.
  task automatic issue_op(cmd_t cmd_v, word_t a_v, word_t b_v);
    int gap;
    alu_out_t expected;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    expected = predict_alu_result(cmd_v, a_v, b_v);
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    command <= cmd_v;
    operand_a <= a_v;
    operand_b <= b_v;
    @(posedge clk);
    while (stall) @(posedge clk);
    predicted_results.push_back(expected);
  endtask

  task automatic compare_field(string name, logic signed [63:0] exp_v,
                               logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // Receiver: with recv_gaps set, waits a random number of cycles after each result, and honors a long hold.
  initial begin : result_side
    int wait_left;
    bit next_stall;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && !result_stall && recv_gaps)
        wait_left = $urandom_range(0, 7);
      if (hold_cycles > 0) begin
        hold_cycles--;
        next_stall = 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      result_stall <= next_stall;
    end
  end

  // Compares every accepted result transaction with the oldest prediction.
  initial begin : result_check
    alu_out_t expected;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $error("result: unexpected transaction, value %0d", result);
        end else begin
          expected = predicted_results.pop_front();
          compare_field("result", expected.value, result);
          compare_field("a_less", expected.lt, a_less);
          compare_field("a_equal", expected.eq, a_equal);
          compare_field("a_greater", expected.gt, a_greater);
          compare_field("divide_by_zero", expected.dz, divide_by_zero);
        end
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("fixed_point_q24_8_alu_tb: done, errors");
        $finish;
      end
    end
  end

  // Every command at its edges: wraps, ties, division by zero, truncation, unused codes.
  task automatic test_directed();
    issue_op(CMD_ADD, WORD_MAX, word_t'(1));
    issue_op(CMD_SUB, WORD_MIN, word_t'(1));
    issue_op(CMD_MUL, WORD_MAX, WORD_MAX);
    issue_op(CMD_MUL, WORD_MIN, WORD_MIN);
    issue_op(CMD_MUL, WORD_MIN, word_t'(-256));
    issue_op(CMD_MUL, word_t'(-1), word_t'(1));
    issue_op(CMD_DIV, word_t'(1234), word_t'(0));
    issue_op(CMD_DIV, word_t'(0), word_t'(0));
    issue_op(CMD_DIV, WORD_MIN, word_t'(-1));
    issue_op(CMD_DIV, word_t'(-256), word_t'(512));
    issue_op(CMD_DIV, word_t'(1), word_t'(-3));
    issue_op(CMD_MIN, word_t'(77), word_t'(77));
    issue_op(CMD_MIN, WORD_MAX, WORD_MIN);
    issue_op(CMD_MAX, word_t'(-5), word_t'(-5));
    issue_op(CMD_MAX, WORD_MIN, WORD_MAX);
    issue_op(CMD_INC, WORD_MAX, word_t'(0));
    issue_op(CMD_DEC, WORD_MIN, word_t'(0));
    issue_op(CMD_TO_INT, word_t'(-1), word_t'(3));
    issue_op(CMD_TO_INT, word_t'(-257), word_t'(0));
    issue_op(CMD_TO_INT, WORD_MIN, WORD_MAX);
    issue_op(CMD_FROM_INT, word_t'(32'sh0080_0000), word_t'(0));
    issue_op(CMD_FROM_INT, word_t'(-1), word_t'(-1));
    issue_op(CMD_UNUSED_LO, word_t'(10), word_t'(-10));
    issue_op(CMD_UNUSED_HI, WORD_MAX, WORD_MAX);
  endtask

  // Random commands and operands; unused codes show up now and then.
  task automatic test_random_traffic(int count);
    cmd_t cmd_v;
    word_t a_v;
    word_t b_v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        cmd_v = cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else
        cmd_v = cmd_t'($urandom_range(CMD_ADD, CMD_FROM_INT));
      a_v = pick_operand();
      b_v = ($urandom_range(0, 7) == 0) ? a_v : pick_operand();
      issue_op(cmd_v, a_v, b_v);
    end
  endtask

  // Full rate on both sides with no idle cycles.
  task automatic test_back_to_back();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_traffic(100);
  endtask

  // The receiver holds off well past the pipeline depth while items keep coming.
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_cycles = 150;
    test_random_traffic(100);
    recv_gaps = 1'b1;
    test_random_traffic(40);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(500);
    test_back_to_back();
    test_backpressure();
    valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("fixed_point_q24_8_alu_tb: done, clean");
    end else begin
      $display("fixed_point_q24_8_alu_tb: done, errors");
    end
    $finish;
  end

endmodule
